>>> rtl/ibm_float_to_ieee_single_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef IBM_FLOAT_TO_IEEE_SINGLE_DEFINES_SVH
`define IBM_FLOAT_TO_IEEE_SINGLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2F_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2F_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/i2f_pkg.sv
// Constants and field widths for the IBM to IEEE single converter.
`default_nettype none
package i2f_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned IEXP_W = 7;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned SE_W   = 11;

    localparam logic [7:0]  EXP_INF  = 8'hff;
    // big_e = p + 4*e - 280 ; subnormal shift k = 4*e - 131
    localparam logic signed [SE_W-1:0] BIGE_OFS = 11'sd280;
    localparam logic signed [SE_W-1:0] SUB_OFS  = 11'sd131;
    localparam logic signed [SE_W-1:0] EMAX     = 11'sd127;
    localparam logic signed [SE_W-1:0] EMIN     = -11'sd126;
    localparam logic signed [SE_W-1:0] EBIAS    = 11'sd127;
    localparam logic signed [SE_W-1:0] SUB_MAXS = 11'sd24;
endpackage
`default_nettype wire

>>> rtl/ibm_float_to_ieee_single.sv
// Top level: pipelined IBM hexadecimal float to IEEE 754 single converter.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  input    | i_ibm_word                              | start high, busy low
//  result   | o_ieee_word, o_overflowed, o_inexact    | o_valid strobe, one cycle
//
// One item per cycle; busy never rises. The pipeline stages are leading-one
// detect, then classify and shift, then round and pack. Each stage register
// carries a valid bit. Synchronous active-low reset clears the valid bits
// only. The receiver cannot hold results off, so nothing ever stalls.
`default_nettype none
`include "ibm_float_to_ieee_single_defines.svh"
module ibm_float_to_ieee_single (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [i2f_pkg::WORD_W-1:0]    i_ibm_word,
    output logic                               o_valid,
    output logic [i2f_pkg::WORD_W-1:0]         o_ieee_word,
    output logic                               o_overflowed,
    output logic                               o_inexact
);
    import i2f_pkg::*;

    // ---------------- stage 1: split fields, find leading one ----------------
    logic                  r_v1;
    logic                  r_sign1;
    logic [IEXP_W-1:0]     r_exp1;
    logic [FRAC_W-1:0]     r_frac1;
    logic [POS_W-1:0]      r_pos1;
    logic [POS_W-1:0]      n_pos1;

    always_comb begin
        n_pos1 = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (i_ibm_word[i]) n_pos1 = POS_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_sign1 <= i_ibm_word[WORD_W-1];
        r_exp1  <= i_ibm_word[WORD_W-2 -: IEXP_W];
        r_frac1 <= i_ibm_word[FRAC_W-1:0];
        r_pos1  <= n_pos1;
    end

    // ---------------- stage 2: classify, shift, collect round bits ----------
    logic signed [SE_W-1:0] big_e;
    logic signed [SE_W-1:0] sub_k;
    logic signed [SE_W-1:0] sub_s;
    logic [SE_W-1:0]        exp4;
    logic [POS_W-1:0]       rsh;
    logic [FRAC_W-1:0]      low_mask;
    logic [FRAC_W-1:0]      norm_sh;
    logic [WORD_W-2:0]      n_mag2;
    logic                   n_inc2, n_inx2, n_ovf2;

    logic                   r_v2, r_sign2, r_inc2, r_inx2, r_ovf2;
    logic [WORD_W-2:0]      r_mag2;

    always_comb begin
        exp4     = {2'b00, r_exp1, 2'b00};
        big_e    = $signed({{(SE_W-POS_W){1'b0}}, r_pos1}) + $signed(exp4) - BIGE_OFS;
        sub_k    = $signed(exp4) - SUB_OFS;
        sub_s    = -sub_k;
        rsh      = sub_s[POS_W-1:0];
        norm_sh  = r_frac1 << (POS_W'(FRAC_W-1) - r_pos1);
        low_mask = (FRAC_W'(1) << (rsh - POS_W'(1))) - FRAC_W'(1);
        n_mag2   = '0;
        n_inc2   = 1'b0;
        n_inx2   = 1'b0;
        n_ovf2   = 1'b0;
        if (r_frac1 == '0) begin
            // signed zero: keep magnitude clear
        end else if (big_e > EMAX) begin
            n_mag2 = {EXP_INF, 23'd0};
            n_ovf2 = 1'b1;
        end else if (big_e >= EMIN) begin
            n_mag2 = {8'(big_e + EBIAS), norm_sh[FRAC_W-2:0]};
        end else if (sub_k >= 0) begin
            n_mag2 = (WORD_W-1)'(r_frac1) << sub_k[POS_W-1:0];
        end else if (sub_s > SUB_MAXS) begin
            // everything shifted out
            n_inx2 = 1'b1;
        end else begin
            n_mag2 = (WORD_W-1)'(r_frac1 >> rsh);
            n_inx2 = |(r_frac1 & ((low_mask << 1) | FRAC_W'(1)));
            // guard and (sticky or lsb)
            n_inc2 = r_frac1[rsh - POS_W'(1)]
                     & ((|(r_frac1 & low_mask)) | n_mag2[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sign2 <= r_sign1;
        r_mag2  <= n_mag2;
        r_inc2  <= n_inc2;
        r_inx2  <= n_inx2;
        r_ovf2  <= n_ovf2;
    end

    // ---------------- stage 3: round and pack ----------------
    logic                  r_v3, r_ovf3, r_inx3;
    logic [WORD_W-1:0]     r_word3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        // rounding up may carry into the smallest normal
        r_word3 <= {r_sign2, r_mag2 + (WORD_W-1)'(r_inc2)};
        r_ovf3  <= r_ovf2;
        r_inx3  <= r_inx2;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_v3;
    assign o_ieee_word  = r_word3;
    assign o_overflowed = r_ovf3;
    assign o_inexact    = r_inx3;

    `I2F_ASSERT_NEXT(a_v1_to_v2, r_v1, r_v2, "stage 2 lost an item")
    `I2F_ASSERT_NEXT(a_v2_to_v3, !r_v2, !o_valid, "result invented")
    `I2F_ASSERT_NOW(a_ovf_exact, o_valid && o_overflowed, !o_inexact, "overflow marked inexact")
    `I2F_ASSERT_NOW(a_ovf_inf, o_valid && o_overflowed, o_ieee_word[30:0] == 31'h7f800000, "overflow not infinity")
endmodule
`default_nettype wire

>>> test/ibm_float_to_ieee_single_tb.sv
// Self-checking testbench for the IBM hexadecimal float to IEEE single converter.
`default_nettype none
module ibm_float_to_ieee_single_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD = 4;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned LATENCY = 3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 1750;

    // One predicted conversion result.
    typedef struct packed {
        logic [i2f_pkg::WORD_W-1:0] ieee_word;
        logic                       overflowed;
        logic                       inexact;
    } conv_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [i2f_pkg::WORD_W-1:0] i_ibm_word = '0;
    logic                       busy;
    logic                       o_valid;
    logic [i2f_pkg::WORD_W-1:0] o_ieee_word;
    logic                       o_overflowed;
    logic                       o_inexact;

    conv_result_t pending_results[$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  overflow_seen = 0;
    int unsigned  inexact_seen = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  idle_pct = 0;

    ibm_float_to_ieee_single u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_ibm_word   (i_ibm_word),
        .o_valid      (o_valid),
        .o_ieee_word  (o_ieee_word),
        .o_overflowed (o_overflowed),
        .o_inexact    (o_inexact)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Convert one IBM word to its IEEE single pattern and flags.
    function automatic conv_result_t ibm_to_ieee(input logic [31:0] word);
        conv_result_t r;
        logic         sgn;
        int           hexp;
        logic [23:0]  frac;
        int           lead;
        int           bin_exp;
        int           shift;
        logic [31:0]  q;
        logic [31:0]  rem;
        logic [31:0]  half;
        sgn  = word[31];
        hexp = int'(word[30:24]);
        frac = word[23:0];
        r    = '0;
        if (frac == 24'd0) begin
            r.ieee_word = {sgn, 31'd0};
        end else begin
            lead = 0;
            for (int b = 0; b < 24; b++)
                if (frac[b]) lead = b;
            bin_exp = lead + 4 * (hexp - 64) - 24;
            if (bin_exp > 127) begin
                r.ieee_word  = {sgn, 8'hff, 23'd0};
                r.overflowed = 1'b1;
            end else if (bin_exp >= -126) begin
                q = {8'd0, frac} << (23 - lead);
                r.ieee_word = {sgn, 8'(bin_exp + 127), q[22:0]};
            end else begin
                // Subnormal: frac scaled into units of the smallest subnormal.
                shift = 4 * hexp - 131;
                if (shift >= 0) begin
                    q = {8'd0, frac} << shift;
                end else if (-shift > 24) begin
                    q = '0;
                    r.inexact = 1'b1;
                end else begin
                    rem  = {8'd0, frac} & ((32'd1 << -shift) - 32'd1);
                    half = 32'd1 << (-shift - 1);
                    q    = {8'd0, frac} >> -shift;
                    if (rem != 0) r.inexact = 1'b1;
                    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
                end
                r.ieee_word = {sgn, 31'd0} | q;
            end
        end
        return r;
    endfunction

    // Check each strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        conv_result_t want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result %h ovf %b inx %b",
                             o_ieee_word, o_overflowed, o_inexact);
            end else begin
                want = pending_results.pop_front();
                if (want.overflowed) overflow_seen <= overflow_seen + 1;
                if (want.inexact) inexact_seen <= inexact_seen + 1;
                if (want.ieee_word !== o_ieee_word || want.overflowed !== o_overflowed
                        || want.inexact !== o_inexact) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: want %h/%b/%b got %h/%b/%b",
                                 want.ieee_word, want.overflowed, want.inexact,
                                 o_ieee_word, o_overflowed, o_inexact);
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing is accepted or delivered.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ibm_float_to_ieee_single_tb: done, errors");
            $finish;
        end
    end

    // Send one item, idling first at the current rate; hold until accepted.
    // Leave start high on return so back-to-back items need no gap.
    task automatic send_item(input logic [31:0] word);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_ibm_word <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(ibm_to_ieee(word));
        items_sent++;
    endtask

    // Drop start and wait until every predicted result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Zero words, extremes and each special case.
    task automatic test_directed();
        send_item(32'h0000_0000);     // all zero
        send_item(32'h8000_0000);     // negative zero
        send_item(32'hff00_0000);     // zero fraction, any exponent
        send_item(32'h4110_0000);     // 1.0
        send_item(32'hc110_0000);     // -1.0
        send_item(32'h4100_0001);     // unnormalized fraction
        send_item(32'h7fff_ffff);     // largest, overflows
        send_item(32'hffff_ffff);     // negative overflow
        send_item(32'h6110_0000);     // exactly 2^128, just at overflow edge
        send_item(32'h60ff_ffff);     // largest finite
        send_item(32'h2180_0000);     // smallest normal region
        send_item(32'h2110_0000);     // subnormal
        send_item(32'h20ff_ffff);     // subnormal, round up with carry
        send_item(32'h1b00_0003);     // tiny values, rounded or flushed to zero
        send_item(32'h1a80_0000);
        send_item(32'h1a80_0001);
        send_item(32'h1b00_0001);
        send_item(32'h00ff_ffff);     // underflow to zero, inexact
        send_item(32'h80ff_ffff);
        send_item(32'h00000001);      // tiniest
        send_item(32'h2300_0001);     // subnormal exact left shift
        send_item(32'h5555_5555);
        send_item(32'haaaa_aaaa);
    endtask

    // Random words at a given sender idle rate, biased toward the edges.
    task automatic test_random(input int unsigned count, input int unsigned pct);
        logic [31:0] word;
        idle_pct = pct;
        for (int unsigned n = 0; n < count; n++) begin
            word = $urandom();
            case ($urandom_range(3, 0))
                0: word[30:24] = 7'($urandom_range('h22, 'h18));  // subnormal band
                1: word[30:24] = 7'($urandom_range('h62, 'h5e));  // overflow band
                2: word[23:0]  = word[23:0] >> $urandom_range(23, 0);
                default: ;
            endcase
            send_item(word);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 37;
        test_directed();
        test_random(RANDOM_ITEMS / 3, 37);
        drain_results();              // full pause with nothing outstanding
        test_random(RANDOM_ITEMS / 3, 58);
        test_random(RANDOM_ITEMS / 3, 0);
        drain_results();
        repeat (LATENCY + 2) @(posedge i_clk);
        $display("covered %0d items, %0d results (%0d overflow, %0d inexact)",
                 items_sent, results_seen, overflow_seen, inexact_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ibm_float_to_ieee_single_tb: done, clean");
        else
            $display("ibm_float_to_ieee_single_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/i2f_pkg.sv
rtl/ibm_float_to_ieee_single.sv
test/ibm_float_to_ieee_single_tb.sv
